// ===== rtl/core/maf_pkg.sv =====
// Shared constants, types and codes for the moving average filter.
// No dependencies; imported by every module of the block.
package maf_pkg;

  // Window store geometry
  localparam int unsigned WINDOW_MAX = 64;
  localparam int unsigned ADDR_W     = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX + 1);

  // Field widths
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned WSIZE_W    = 7;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned RECIP_W    = FRAC_BITS + 1;
  localparam int unsigned SUM_W      = SAMPLE_W + ADDR_W;
  localparam int unsigned PROD_W     = SUM_W + RECIP_W + 1;
  localparam int unsigned TRUNC_W    = PROD_W - FRAC_BITS;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = RECIP_W;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RECIPROCAL  = 1'b1;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(16);
  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(4096);

  // Request actions
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Output queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       average_valid;
  } result_t;

endpackage

// ===== rtl/core/moving_average_filter.sv =====
// Boxcar moving average over the last window_size signed Q16.16 samples, scaled by a
// software-set Q1.16 reciprocal. Sustains one request per clock while the input is not
// stalled. A result reaches the output in these steps: the store read happens at
// acceptance, then come the sum update, the multiplier register and the scaled write into
// the output queue. At most eight requests are outstanding in the pipeline and the output
// queue together; beyond that the input stalls. A write of window_size starts a
// re-summing pass through the store's single read port. The pass reads each entry of the
// effective window (zero counts as one, above the depth counts as the depth). Requests and
// further configuration writes wait during the pass. Requests also stall while a
// configuration write is offered. That write is taken once nothing is in flight. The
// store is empty after reset with no clearing pass.
module moving_average_filter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic signed [maf_pkg::SAMPLE_W-1:0] sample_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [maf_pkg::SAMPLE_W-1:0] average_o,
  output logic                             average_valid_o,
  // Configuration channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [maf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [maf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import maf_pkg::*;

  // Configuration registers
  logic [WSIZE_W-1:0] wsize_q;
  logic [RECIP_W-1:0] recip_q;
  logic [CNT_W-1:0]   n_win;

  // Control state
  logic [ADDR_W-1:0]  wpos_q;
  logic               full_q;
  sum_t               sum_q;
  logic [WINDOW_MAX-1:0] vbits_q;
  logic [FIFO_CNT_W-1:0] pending_q;

  // Store and read port
  logic [SAMPLE_W-1:0] mem [WINDOW_MAX];
  logic [ADDR_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_q;
  logic                rdv_q;

  // Re-summing pass
  logic               sw_issue_q;
  logic [ADDR_W-1:0]  sw_idx_q;
  logic               sw_acc_q;
  logic               busy;

  // Pipeline stages
  logic               s1_valid_q, s1_clear_q, s1_inwin_q, s1_report_q, s1_fwd_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic [SAMPLE_W-1:0] s1_sample_q, s1_fwd_data_q;
  logic               s2_valid_q, s2_report_q;
  logic               s3_valid_q, s3_report_q;
  prod_t              prod_q;

  logic               in_acc, cfg_acc, pop;
  logic [ADDR_W-1:0]  next_pos;
  logic [SAMPLE_W-1:0] old_val;
  prod_t              recip_ext, biased;
  logic [TRUNC_W-1:0] trunc;
  logic signed [SAMPLE_W-1:0] sat;
  result_t            res, out_res;

  // Effective window: zero acts as one, above the depth acts as the depth
  always_comb begin
    if (wsize_q == '0)                           n_win = CNT_W'(1);
    else if (CNT_W'(wsize_q) > CNT_W'(WINDOW_MAX)) n_win = CNT_W'(WINDOW_MAX);
    else                                         n_win = CNT_W'(wsize_q);
  end

  // Configuration takes precedence: requests hold while a write is offered
  assign busy        = sw_issue_q || sw_acc_q;
  assign in_stall_o  = busy || cfg_valid_i || (pending_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign cfg_ready_o = !busy && (pending_q == '0);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign pop         = out_valid_o && !out_stall_i;

  // Next write position: wraps after the window end or the store end
  assign next_pos = ({1'b0, wpos_q} == CNT_W'(n_win - 1'b1)) ? '0 : wpos_q + 1'b1;

  assign rd_addr = sw_issue_q ? sw_idx_q : wpos_q;

  // Store: written by the sum stage, read through a registered port
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && !s1_clear_q) begin
      mem[s1_addr_q] <= s1_sample_q;
    end
    rd_q <= mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WSIZE_RESET;
      recip_q <= RECIP_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_index_i)
        REG_WINDOW_SIZE: wsize_q <= cfg_data_i[WSIZE_W-1:0];
        REG_RECIPROCAL:  recip_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Old entry seen by the sum stage, forwarded past the write of the request ahead
  assign old_val = s1_fwd_q ? s1_fwd_data_q : (rdv_q ? rd_q : '0);

  // Position, full flag, entry valid bits, running sum and re-summing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q     <= '0;
      full_q     <= 1'b0;
      sum_q      <= '0;
      vbits_q    <= '0;
      rdv_q      <= 1'b0;
      sw_issue_q <= 1'b0;
      sw_idx_q   <= '0;
      sw_acc_q   <= 1'b0;
    end else begin
      rdv_q    <= vbits_q[rd_addr];
      sw_acc_q <= sw_issue_q;

      // Position and full flag move at acceptance
      if (in_acc) begin
        if (action_i == ACT_CLEAR) begin
          full_q <= 1'b0;
        end else begin
          wpos_q <= next_pos;
          if (!full_q && ({1'b0, next_pos} == CNT_W'(n_win - 1'b1))) full_q <= 1'b1;
        end
      end

      // Store contents and sum change in the sum stage
      if (s1_valid_q) begin
        if (s1_clear_q) begin
          vbits_q <= '0;
          sum_q   <= '0;
        end else begin
          vbits_q[s1_addr_q] <= 1'b1;
          if (s1_inwin_q) begin
            sum_q <= sum_q + sum_t'($signed(s1_sample_q)) - sum_t'($signed(old_val));
          end
        end
      end

      // Re-summing pass after a window size write
      if (cfg_acc && (cfg_index_i == REG_WINDOW_SIZE)) begin
        sw_issue_q <= 1'b1;
        sw_idx_q   <= '0;
        sum_q      <= '0;
      end else if (sw_issue_q) begin
        if ({1'b0, sw_idx_q} == CNT_W'(n_win - 1'b1)) sw_issue_q <= 1'b0;
        sw_idx_q <= sw_idx_q + 1'b1;
      end
      if (sw_acc_q && rdv_q) begin
        sum_q <= sum_q + sum_t'($signed(rd_q));
      end
    end
  end

  // Stage 1: request captured alongside the store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_clear_q    <= (action_i == ACT_CLEAR);
      s1_addr_q     <= wpos_q;
      s1_sample_q   <= sample_i;
      s1_inwin_q    <= ({1'b0, wpos_q} < n_win);
      s1_report_q   <= (action_i == ACT_PUSH) && full_q;
      s1_fwd_q      <= s1_valid_q && (s1_clear_q || (s1_addr_q == wpos_q));
      s1_fwd_data_q <= s1_clear_q ? '0 : s1_sample_q;
    end
  end

  // Stages 2 and 3: multiply the updated sum, then scale
  assign recip_ext = prod_t'($signed({1'b0, recip_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_report_q <= s1_report_q;
    s3_report_q <= s2_report_q;
    prod_q      <= prod_t'(sum_q) * recip_ext;
  end

  // Truncate toward zero, then saturate to 32 bits
  assign biased = prod_q + (prod_q[PROD_W-1] ? prod_t'((1 << FRAC_BITS) - 1) : prod_t'(0));
  assign trunc  = biased[PROD_W-1:FRAC_BITS];

  always_comb begin
    if ((&trunc[TRUNC_W-1:SAMPLE_W-1]) || !(|trunc[TRUNC_W-1:SAMPLE_W-1])) begin
      sat = trunc[SAMPLE_W-1:0];
    end else if (trunc[TRUNC_W-1]) begin
      sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  assign res.average       = s3_report_q ? sat : '0;
  assign res.average_valid = s3_report_q;

  // Requests accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !pop) begin
      pending_q <= pending_q + 1'b1;
    end else if (!in_acc && pop) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  maf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_valid_q),
    .push_data_i (res),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .data_o      (out_res)
  );

  assign average_o       = out_res.average;
  assign average_valid_o = out_res.average_valid;

  // Checks
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("pending count above queue depth");

  a_sweep_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sw_acc_q |-> !s1_valid_q && !s2_valid_q && !s3_valid_q)
    else $error("re-summing pass overlaps a request in flight");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_clear_q && !cfg_acc) |=> (sum_q == '0) && (vbits_q == '0))
    else $error("clear left store or sum non-zero");

  a_out_when_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != '0))
    else $error("result shown with nothing pending");

  a_unreported_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && !s3_report_q) |-> (res.average == '0))
    else $error("non-valid result carries a value");

endmodule

// ===== rtl/core/maf_out_fifo.sv =====
// Output queue for the moving average filter: holds finished results until taken.
// Depends on maf_pkg for depth and the result type.
module maf_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  maf_pkg::result_t push_data_i,
  input  logic            pop_i,
  output logic            valid_o,
  output maf_pkg::result_t data_o
);
  import maf_pkg::*;

  result_t                 store_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   count_q;

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];

endmodule
